// ----- src/emc_pkg.sv -----
// ----------------------------------------------------------------------------
// emc_pkg
// Shared widths, reset values and state encoding for the max-cut search core.
// ----------------------------------------------------------------------------
package emc_pkg;

    localparam int DATA_W           = 16;
    localparam int RESULT_W         = 24;
    localparam int CFG_W            = 5;
    localparam int MAX_NODES_DEF    = 16;
    localparam int NODE_COUNT_RESET = 16;

    localparam logic [RESULT_W-1:0] SUM_MAX = {RESULT_W{1'b1}};

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SEARCH,
        ST_FINISH,
        ST_DONE
    } emc_state_t;

endpackage

// ----- src/exhaustive_max_cut_core.sv -----
// ----------------------------------------------------------------------------
// exhaustive_max_cut_core
// Brute-force maximum directed cut over a small weighted graph.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_we/cfg_wdata set the node count n (0 acts as 1, values above MAX_NODES
//   saturate). A write also restarts loading of the matrix.
//   The s_ channel takes the n*n weight matrix in row-major order, one beat
//   per cycle. After the last beat the core stops taking input and searches
//   every split of the nodes with node n-1 held on side A, then puts the
//   largest cut sum on the m_ channel.
//   While searching, the core makes one memory read per cycle through the
//   single read port; each read feeds the accumulate stage, which also does
//   the compare. For n = 1 the core skips the search and the result is zero.
//   Input stays closed until the result is in the output register.
//   The result sits in an output register: loading of the next matrix may
//   start while it waits. If a second search ends before the receiver takes
//   the first result, the core holds until the output register frees up.
//   Reset (aresetn low, synchronous) sets n to 16 (or MAX_NODES if smaller),
//   empties the output register and restarts loading; memory is not cleared.
// ----------------------------------------------------------------------------
module exhaustive_max_cut_core #(
    parameter int MAX_NODES = emc_pkg::MAX_NODES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [emc_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [emc_pkg::DATA_W-1:0]   s_edge_weight,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [emc_pkg::RESULT_W-1:0] m_max_cut_weight
);
    import emc_pkg::*;

    localparam int DEPTH   = MAX_NODES * MAX_NODES;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int CNT_W   = $clog2(MAX_NODES + 1);
    localparam int MASK_W  = MAX_NODES - 1;
    localparam int SUM_W   = (DATA_W + ADDR_W > RESULT_W) ? DATA_W + ADDR_W : RESULT_W;
    localparam int N_RST   = (NODE_COUNT_RESET < MAX_NODES) ? NODE_COUNT_RESET : MAX_NODES;

    emc_state_t state_reg, state_next;

    logic [ADDR_W-1:0]   load_reg, load_next;
    logic [NODE_W-1:0]   a_reg, a_next, b_reg, b_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [MASK_W-1:0]   subset_reg, subset_next;
    logic                p1_valid_reg, p1_valid_next;
    logic                p1_take_reg, p1_take_next;
    logic                p1_first_reg, p1_first_next;
    logic                p1_last_reg, p1_last_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [RESULT_W-1:0] best_reg, best_next;
    logic                m_valid_reg, m_valid_next;
    logic [RESULT_W-1:0] m_data_reg, m_data_next;
    logic [NODE_W-1:0]   n_m1_reg, n_m1_next, n_m2_reg, n_m2_next;
    logic [ADDR_W-1:0]   last_addr_reg, last_addr_next;

    logic [CFG_W-1:0]     cfg_n;
    logic [2*CNT_W-1:0]   cfg_sq;
    logic [MAX_NODES-1:0] side;
    logic [MASK_W-1:0]    mask_last;
    logic [DATA_W-1:0]    rd_data;
    logic [RESULT_W-1:0]  cand;
    logic                 s_fire;

    assign s_ready = (state_reg == ST_LOAD);
    assign s_fire  = s_valid && s_ready;

    emc_weight_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (s_fire),
        .wr_addr (load_reg),
        .wr_data (s_edge_weight),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    // node count after clamping, and what follows from it
    always_comb begin
        if (cfg_wdata == '0) begin
            cfg_n = CFG_W'(1);
        end else if (cfg_wdata > CFG_W'(MAX_NODES)) begin
            cfg_n = CFG_W'(MAX_NODES);
        end else begin
            cfg_n = cfg_wdata;
        end
        cfg_sq = CNT_W'(cfg_n) * CNT_W'(cfg_n);
    end

    // side A membership: subset bits plus the fixed last node
    always_comb begin
        side                = '0;
        side[MASK_W-1:0]    = subset_reg;
        side[n_m1_reg]      = 1'b1;
        for (int i = 0; i < MASK_W; i++) begin
            mask_last[i] = (NODE_W'(i) < n_m1_reg);
        end
    end

    always_comb begin
        state_next     = state_reg;
        load_next      = load_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        addr_next      = addr_reg;
        subset_next    = subset_reg;
        p1_valid_next  = 1'b0;
        p1_take_next   = side[a_reg] && !side[b_reg];
        p1_first_next  = (a_reg == '0) && (b_reg == '0);
        p1_last_next   = (a_reg == n_m1_reg) && (b_reg == n_m2_reg);
        sum_next       = sum_reg;
        best_next      = best_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        n_m1_next      = n_m1_reg;
        n_m2_next      = n_m2_reg;
        last_addr_next = last_addr_reg;
        cand           = '0;

        // accumulate stage, in the cycle after the memory read
        if (p1_valid_reg) begin
            sum_next = (p1_first_reg ? '0 : sum_reg)
                     + (p1_take_reg ? SUM_W'(rd_data) : '0);
            cand = (sum_next > SUM_W'(SUM_MAX)) ? SUM_MAX : sum_next[RESULT_W-1:0];
            if (p1_last_reg && (cand > best_reg)) begin
                best_next = cand;
            end
        end

        case (state_reg)
            ST_LOAD: begin
                if (s_fire) begin
                    if (load_reg == last_addr_reg) begin
                        load_next   = '0;
                        best_next   = '0;
                        a_next      = '0;
                        b_next      = '0;
                        addr_next   = '0;
                        subset_next = '0;
                        state_next  = (n_m1_reg == '0) ? ST_DONE : ST_SEARCH;
                    end else begin
                        load_next = load_reg + 1'b1;
                    end
                end
            end
            ST_SEARCH: begin
                p1_valid_next = 1'b1;
                if (b_reg == n_m2_reg) begin
                    b_next = '0;
                    if (a_reg == n_m1_reg) begin
                        a_next      = '0;
                        addr_next   = '0;
                        subset_next = subset_reg + 1'b1;
                        if (subset_reg == mask_last) begin
                            state_next = ST_FINISH;
                        end
                    end else begin
                        a_next    = a_reg + 1'b1;
                        // skip the column of the fixed node
                        addr_next = addr_reg + ADDR_W'(2);
                    end
                end else begin
                    b_next    = b_reg + 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = best_reg;
                    state_next   = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase

        if (cfg_we) begin
            load_next      = '0;
            n_m1_next      = NODE_W'(cfg_n - 1'b1);
            n_m2_next      = NODE_W'(cfg_n - CFG_W'(2));
            last_addr_next = ADDR_W'(cfg_sq - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            load_reg      <= '0;
            p1_valid_reg  <= 1'b0;
            best_reg      <= '0;
            m_valid_reg   <= 1'b0;
            n_m1_reg      <= NODE_W'(N_RST - 1);
            n_m2_reg      <= NODE_W'(N_RST - 2);
            last_addr_reg <= ADDR_W'(N_RST * N_RST - 1);
        end else begin
            state_reg     <= state_next;
            load_reg      <= load_next;
            p1_valid_reg  <= p1_valid_next;
            best_reg      <= best_next;
            m_valid_reg   <= m_valid_next;
            n_m1_reg      <= n_m1_next;
            n_m2_reg      <= n_m2_next;
            last_addr_reg <= last_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        addr_reg     <= addr_next;
        subset_reg   <= subset_next;
        p1_take_reg  <= p1_take_next;
        p1_first_reg <= p1_first_next;
        p1_last_reg  <= p1_last_next;
        sum_reg      <= sum_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_max_cut_weight = m_data_reg;

endmodule

// ----- src/emc_weight_ram.sv -----
// ----------------------------------------------------------------------------
// emc_weight_ram
// Weight matrix storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module emc_weight_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [emc_pkg::DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [emc_pkg::DATA_W-1:0] rd_data
);
    import emc_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/emc_checker.sv -----
// ----------------------------------------------------------------------------
// emc_checker
// Port-level checks for the max-cut core, bound to the top level.
// ----------------------------------------------------------------------------
module emc_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [emc_pkg::RESULT_W-1:0] m_max_cut_weight
);
    import emc_pkg::*;

    // reset empties the output register
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_max_cut_weight)))
        else $error("result beat changed while stalled");

    // input closes only after the last matrix beat is taken
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid && s_ready))
        else $error("s_ready fell without an accepted beat");

    // a new result only comes out of a finished search, never during loading
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared while loading");

endmodule

bind exhaustive_max_cut_core emc_checker u_emc_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_max_cut_weight (m_max_cut_weight)
);

// ----- verif/exhaustive_max_cut_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// exhaustive_max_cut_core_tb
// Streams weight matrices of random size and content into the max-cut core
// under bursty input and a stalling receiver. Results are checked beat by
// beat against a behavioral search over the same matrix, with node-count
// writes between phases and partial loads that are restarted by a write.
// ----------------------------------------------------------------------------
module exhaustive_max_cut_core_tb;
    import emc_pkg::*;

    typedef enum int {
        W_FULL,
        W_SMALL,
        W_SPARSE,
        W_MAX,
        W_ZERO,
        W_ALT
    } weight_style_t;

    localparam int MATRIX_DEPTH = MAX_NODES_DEF * MAX_NODES_DEF;
    localparam int RANDOM_BEATS = 650;
    localparam int MIN_RESULTS  = 45;
    localparam int RX_HOLD_LEN  = 400;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                cfg_we        = 1'b0;
    logic [CFG_W-1:0]    cfg_wdata     = '0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [DATA_W-1:0]   s_edge_weight = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic [RESULT_W-1:0] m_max_cut_weight;

    logic [DATA_W-1:0]   weight_beats[$];
    logic [RESULT_W-1:0] cut_expect_q[$];

    // shadow of the core: node count register and the matrix being loaded
    logic [CFG_W-1:0]    model_nodes;
    logic [DATA_W-1:0]   load_buf[MATRIX_DEPTH];
    int                  load_pos;

    int unsigned         burst_left = 0;
    int unsigned         gap_left   = 0;
    logic                rx_hold_kick = 1'b0;
    logic                rx_kick_seen = 1'b0;
    int unsigned         rx_stall_left = 0;
    logic [9:0]          rx_cycle = '0;

    int                  fail_count     = 0;
    longint              cycle_count    = 0;
    longint              cycle_budget   = 0;
    int                  beats_queued   = 0;
    int                  matrices_queued = 0;

    exhaustive_max_cut_core i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_edge_weight    (s_edge_weight),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_max_cut_weight (m_max_cut_weight)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // largest directed cut of the loaded matrix, node n-1 pinned to side A
    function automatic logic [RESULT_W-1:0] best_directed_cut(input int n);
        longint best;
        longint sum;
        int     mask;
        int     a;
        int     b;
        best = 0;
        for (mask = 0; mask < (1 << (n - 1)); mask++) begin
            sum = 0;
            for (a = 0; a < n; a++) begin
                if (a == n - 1 || ((mask >> a) & 1) == 1) begin
                    for (b = 0; b < n - 1; b++) begin
                        if (((mask >> b) & 1) == 0) begin
                            sum += load_buf[a * n + b];
                        end
                    end
                end
            end
            if (sum > best) begin
                best = sum;
            end
        end
        if (best > SUM_MAX) begin
            best = SUM_MAX;
        end
        return best[RESULT_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] pick_weight(input weight_style_t style, input int idx);
        case (style)
            W_SMALL:  return DATA_W'($urandom_range(0, 15));
            W_SPARSE: return ($urandom_range(0, 3) == 0) ? DATA_W'($urandom) : '0;
            W_MAX:    return '1;
            W_ZERO:   return '0;
            W_ALT:    return idx[0] ? '0 : '1;
            default:  return DATA_W'($urandom);
        endcase
    endfunction

    // one full matrix; budget covers worst gaps, the search and a long receiver stall
    task automatic queue_matrix(input int n, input weight_style_t style);
        int i;
        for (i = 0; i < n * n; i++) begin
            weight_beats.push_back(pick_weight(style, i));
        end
        beats_queued    += n * n;
        matrices_queued += 1;
        cycle_budget    += n * n * 8 + (longint'(1) << (n - 1)) * n * (n - 1) + 3
                           + RX_HOLD_LEN + 100;
    endtask

    // beats that leave the load unfinished
    task automatic queue_partial(input int count);
        int i;
        for (i = 0; i < count; i++) begin
            weight_beats.push_back(DATA_W'($urandom));
        end
        beats_queued += count;
        cycle_budget += count * 8;
    endtask

    // all beats taken, all results out, then a short settle
    task automatic wait_drained();
        while (weight_beats.size() != 0 || s_valid || cut_expect_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (10) @(negedge aclk);
        cycle_budget += 20;
    endtask

    task automatic write_node_count(input logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
        cycle_budget += 4;
    endtask

    // sender: bursts of random length, random gaps in between
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (weight_beats.size() != 0) begin
                s_valid       <= 1'b1;
                s_edge_weight <= weight_beats.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: rotating ready pattern, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready       <= 1'b0;
            rx_stall_left <= 0;
            rx_kick_seen  <= 1'b0;
        end else if (rx_hold_kick != rx_kick_seen) begin
            rx_kick_seen  <= rx_hold_kick;
            rx_stall_left <= RX_HOLD_LEN;
            m_ready       <= 1'b0;
        end else if (rx_stall_left != 0) begin
            rx_stall_left <= rx_stall_left - 1;
            m_ready       <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1'b1;
            case (rx_cycle[9:7])
                3'd0, 3'd1: begin
                    m_ready <= 1'b1;
                end
                3'd2: begin
                    m_ready <= (rx_cycle[1:0] == 2'd0);
                end
                default: begin
                    m_ready <= ($urandom_range(0, 9) < 6);
                end
            endcase
        end
    end

    // monitor: check the result beat, then fold the input beat into the shadow
    always @(posedge aclk) begin
        int                  n;
        logic [RESULT_W-1:0] want;
        if (!aresetn) begin
            model_nodes = CFG_W'(NODE_COUNT_RESET);
            load_pos    = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (cut_expect_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: result %0d with nothing outstanding",
                                 $realtime, m_max_cut_weight);
                    end
                end else begin
                    want = cut_expect_q.pop_front();
                    if (m_max_cut_weight !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: max_cut_weight mismatch, expected %0d, got %0d",
                                     $realtime, want, m_max_cut_weight);
                        end
                    end
                end
            end
            if (cfg_we) begin
                model_nodes = cfg_wdata;
                load_pos    = 0;
            end else if (s_valid && s_ready) begin
                n = model_nodes;
                if (n == 0) begin
                    n = 1;
                end
                if (n > MAX_NODES_DEF) begin
                    n = MAX_NODES_DEF;
                end
                if (load_pos >= n * n) begin
                    load_pos = 0;
                end
                load_buf[load_pos] = s_edge_weight;
                load_pos++;
                if (load_pos == n * n) begin
                    cut_expect_q.push_back(best_directed_cut(n));
                    load_pos = 0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3 * cycle_budget + 20000) begin
            $display("%0t: timeout", $realtime);
            $display("exhaustive_max_cut_core_tb: done, errors");
            $finish;
        end
    end

    initial begin
        int            n;
        int            mats;
        int            k;
        weight_style_t style;
        cycle_budget = 200;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // partial load at the reset node count, restarted by the next write
        queue_partial(5);
        wait_drained();
        // zero node count acts as one node
        write_node_count(5'd0);
        queue_matrix(1, W_ZERO);
        queue_matrix(1, W_MAX);
        wait_drained();
        write_node_count(5'd2);
        queue_matrix(2, W_MAX);
        wait_drained();
        // oversize count saturates; leave it partial and restart
        write_node_count(5'd31);
        queue_partial(3);
        wait_drained();
        write_node_count(5'd3);
        queue_matrix(3, W_ALT);
        wait_drained();

        // receiver holds off while single-node problems pile up
        write_node_count(5'd1);
        rx_hold_kick <= ~rx_hold_kick;
        for (k = 0; k < 24; k++) begin
            queue_matrix(1, W_FULL);
        end
        wait_drained();

        // the largest full search of the run
        write_node_count(5'd12);
        queue_matrix(12, W_FULL);
        wait_drained();

        while (beats_queued < RANDOM_BEATS || matrices_queued < MIN_RESULTS) begin
            k = $urandom_range(0, 99);
            if (k < 45) begin
                n = $urandom_range(1, 3);
            end else if (k < 85) begin
                n = $urandom_range(4, 6);
            end else if (k < 97) begin
                n = $urandom_range(7, 8);
            end else begin
                n = $urandom_range(9, 10);
            end
            write_node_count((n == 1 && $urandom_range(0, 1) == 0) ? 5'd0 : CFG_W'(n));
            if ($urandom_range(0, 7) == 0) begin
                rx_hold_kick <= ~rx_hold_kick;
            end
            mats = $urandom_range(1, 4);
            for (k = 0; k < mats; k++) begin
                case ($urandom_range(0, 9))
                    6:       style = W_SMALL;
                    7:       style = W_SPARSE;
                    8:       style = W_MAX;
                    9:       style = W_ZERO;
                    default: style = W_FULL;
                endcase
                queue_matrix(n, style);
                // sometimes let every result come out before the next matrix
                if ($urandom_range(0, 3) == 0) begin
                    wait_drained();
                end
            end
            if (n > 1 && $urandom_range(0, 4) == 0) begin
                queue_partial($urandom_range(1, n * n - 1));
            end else if ($urandom_range(0, 9) == 0) begin
                wait_drained();
                write_node_count(CFG_W'($urandom_range(16, 31)));
                queue_partial($urandom_range(1, 60));
            end
            wait_drained();
        end

        wait_drained();
        repeat (20) @(negedge aclk);
        if (cut_expect_q.size() != 0) begin
            fail_count++;
            $display("%0d results never arrived", cut_expect_q.size());
        end
        if (fail_count == 0) begin
            $display("exhaustive_max_cut_core_tb: done, clean");
        end else begin
            $display("exhaustive_max_cut_core_tb: done, errors");
        end
        $finish;
    end

endmodule
